@@ hw/rtl/ircfp_pkg.sv @@
// shared types and constants of the ir command frame parser
package ircfp_pkg;

   localparam int StateW = 5;

   // parser state codes
   localparam logic [StateW-1:0] ST_SYNC     = 5'd0;
   localparam logic [StateW-1:0] ST_CODE     = 5'd1;
   localparam logic [StateW-1:0] ST_REPEAT   = 5'd2;
   localparam logic [StateW-1:0] ST_DUTY     = 5'd3;
   localparam logic [StateW-1:0] ST_CAR_HI   = 5'd4;
   localparam logic [StateW-1:0] ST_CAR_LO   = 5'd5;
   localparam logic [StateW-1:0] ST_PW_FIRST = 5'd6;
   localparam logic [StateW-1:0] ST_PW_WLO   = 5'd7;
   localparam logic [StateW-1:0] ST_PW_L2    = 5'd8;
   localparam logic [StateW-1:0] ST_PW_L3    = 5'd9;
   localparam logic [StateW-1:0] ST_PW_L4    = 5'd10;
   localparam logic [StateW-1:0] ST_CHECK    = 5'd11;
   localparam logic [StateW-1:0] ST_PB       = 5'd12;
   localparam logic [StateW-1:0] ST_PW_HI    = 5'd13;
   localparam logic [StateW-1:0] ST_PW_LO    = 5'd14;
   localparam logic [StateW-1:0] ST_PD1      = 5'd15;
   localparam logic [StateW-1:0] ST_PD2      = 5'd16;
   localparam logic [StateW-1:0] ST_PD3      = 5'd17;
   localparam logic [StateW-1:0] ST_PD4      = 5'd18;

   // event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_RESTART = 2'd1;
   localparam logic [1:0] EV_PULSE   = 2'd2;
   localparam logic [1:0] EV_DONE    = 2'd3;

   // register indexes
   localparam logic [2:0] REG_SYNC_VALUE     = 3'd0;
   localparam logic [2:0] REG_CODE_ONLY_MIN  = 3'd1;
   localparam logic [2:0] REG_BYTE_PARAM_MIN = 3'd2;
   localparam logic [2:0] REG_WORD_PARAM_MIN = 3'd3;
   localparam logic [2:0] REG_DWORD_PARAM_MIN = 3'd4;
   localparam logic [2:0] REG_TRANSMIT_CODE  = 3'd5;

   localparam logic [7:0]  END_MARK       = 8'hff;
   localparam logic [7:0]  DUTY_MAX       = 8'd100;
   localparam logic [31:0] PW_MASK        = 32'h7fff_ffff;
   localparam logic [31:0] PERIOD_NONE    = 32'hffff_ffff;
   localparam logic [31:0] PERIOD_RESET   = 32'(48000000 / 38000);
   localparam logic [6:0]  DUTY_RESET     = 7'd33;
   localparam logic [7:0]  COMMAND_RESET  = 8'hfe;
   localparam logic [7:0]  CHECKSUM_RESET = 8'hff;

   typedef struct packed {
      logic [7:0] sync_value;
      logic [7:0] code_only_min;
      logic [7:0] byte_param_min;
      logic [7:0] word_param_min;
      logic [7:0] dword_param_min;
      logic [7:0] transmit_code;
   } cfg_type;

   typedef struct packed {
      logic [StateW-1:0] parse_state;
      logic [31:0]       assembly;
      logic [7:0]        checksum;
      logic              checksum_done;
      logic [7:0]        command;
      logic [31:0]       parameter_value;
      logic [7:0]        repeat_count;
      logic [6:0]        duty;
      logic [31:0]       period;
   } parse_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [30:0] pulse_width;
   } event_type;

endpackage

@@ hw/rtl/ircfp_step.sv @@
// next-state logic of the parser for one received byte
module ircfp_step (
   input  ircfp_pkg::cfg_type   cfg,
   input  ircfp_pkg::parse_type cur,
   input  logic [7:0]           rx_byte,
   output ircfp_pkg::parse_type nxt,
   output ircfp_pkg::event_type evt
);
   import ircfp_pkg::*;

   logic [31:0] shifted;
   logic [15:0] car_word;
   logic [31:0] car_period;

   assign shifted    = {cur.assembly[23:0], rx_byte};
   assign car_word   = {cur.assembly[7:0], rx_byte};
   // carrier word is at most 16 bits, so the shift cannot overflow
   assign car_period = 32'(car_word >> 3);

   always_comb begin
      nxt = cur;
      evt.event_res = EV_NONE;
      evt.pulse_width = '0;
      if (cur.parse_state != ST_SYNC && cur.parse_state != ST_CODE) begin
         nxt.checksum = cur.checksum ^ rx_byte;
      end
      case (cur.parse_state)
         ST_SYNC: begin
            if (rx_byte == cfg.sync_value) nxt.parse_state = ST_CODE;
         end
         ST_CODE: begin
            if (rx_byte != cfg.sync_value) begin
               nxt.checksum = rx_byte;
               nxt.command = rx_byte;
               nxt.parameter_value = '0;
               nxt.checksum_done = 1'b0;
               if (rx_byte >= cfg.code_only_min) nxt.parse_state = ST_CHECK;
               else if (rx_byte >= cfg.byte_param_min) nxt.parse_state = ST_PB;
               else if (rx_byte >= cfg.word_param_min) nxt.parse_state = ST_PW_HI;
               else if (rx_byte >= cfg.dword_param_min) nxt.parse_state = ST_PD1;
               else if (rx_byte == cfg.transmit_code) nxt.parse_state = ST_REPEAT;
               else nxt.parse_state = ST_CHECK;
            end
         end
         ST_REPEAT: begin
            nxt.repeat_count = rx_byte;
            nxt.parse_state = ST_DUTY;
         end
         ST_DUTY: begin
            if (rx_byte <= DUTY_MAX) begin
               nxt.duty = rx_byte[6:0];
               nxt.parse_state = ST_CAR_HI;
            end else begin
               nxt.parse_state = ST_CHECK;
            end
         end
         ST_CAR_HI: begin
            if (rx_byte != END_MARK) begin
               nxt.assembly = 32'(rx_byte);
               nxt.parse_state = ST_CAR_LO;
            end else begin
               nxt.parse_state = ST_CHECK;
            end
         end
         ST_CAR_LO: begin
            nxt.assembly = car_period;
            nxt.period = (car_period == '0) ? PERIOD_NONE : car_period;
            evt.event_res = EV_RESTART;
            nxt.parse_state = ST_PW_FIRST;
         end
         ST_PW_FIRST: begin
            if (rx_byte == END_MARK) begin
               nxt.parse_state = ST_CHECK;
            end else begin
               nxt.assembly = 32'(rx_byte);
               nxt.parse_state = rx_byte[7] ? ST_PW_L2 : ST_PW_WLO;
            end
         end
         ST_PW_WLO: begin
            nxt.assembly = shifted;
            evt.pulse_width = shifted[30:0];
            evt.event_res = EV_PULSE;
            nxt.parse_state = ST_PW_FIRST;
         end
         ST_PW_L2, ST_PW_L3, ST_PD2, ST_PD3: begin
            nxt.assembly = shifted;
            nxt.parse_state = cur.parse_state + 5'd1;
         end
         ST_PW_L4: begin
            nxt.assembly = shifted & PW_MASK;
            evt.pulse_width = shifted[30:0];
            evt.event_res = EV_PULSE;
            nxt.parse_state = ST_PW_FIRST;
         end
         ST_PB: begin
            nxt.parameter_value = 32'(rx_byte);
            nxt.parse_state = ST_CHECK;
         end
         ST_PW_HI, ST_PD1: begin
            nxt.assembly = 32'(rx_byte);
            nxt.parse_state = cur.parse_state + 5'd1;
         end
         ST_PW_LO, ST_PD4: begin
            nxt.parameter_value = shifted;
            nxt.parse_state = ST_CHECK;
         end
         ST_CHECK: begin
            nxt.checksum_done = 1'b1;
            evt.event_res = EV_DONE;
            nxt.parse_state = ST_SYNC;
         end
         default: begin
            nxt.parse_state = ST_SYNC;
         end
      endcase
   end

endmodule

@@ hw/rtl/ir_command_frame_parser.sv @@
// top level of the ir command frame parser
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_ready  | event, pulse width and latched frame fields
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
// one item per cycle: each byte goes through one step of the parse logic into the
// result register, so the result appears in the cycle after the item is taken.
// a stalled result blocks a new item only while rsp_ready is low.
// reset is synchronous: parser waits for sync, config and parse registers take their default values.
module ir_command_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [30:0] rsp_pulse_width,
   output logic [7:0]  rsp_command_code,
   output logic [31:0] rsp_parameter_value,
   output logic [7:0]  rsp_repeat_count,
   output logic [6:0]  rsp_duty_cycle,
   output logic [31:0] rsp_carrier_period,
   output logic [7:0]  rsp_running_checksum,
   output logic        rsp_checksum_closed,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import ircfp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   parse_type parse_ff, parse_nxt;
   event_type evt;
   event_type evt_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SYNC_VALUE:      cfg_in.sync_value = csr_wdata;
            REG_CODE_ONLY_MIN:   cfg_in.code_only_min = csr_wdata;
            REG_BYTE_PARAM_MIN:  cfg_in.byte_param_min = csr_wdata;
            REG_WORD_PARAM_MIN:  cfg_in.word_param_min = csr_wdata;
            REG_DWORD_PARAM_MIN: cfg_in.dword_param_min = csr_wdata;
            REG_TRANSMIT_CODE:   cfg_in.transmit_code = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   ircfp_step u_step (
      .cfg     (cfg_ff),
      .cur     (parse_ff),
      .rx_byte (req_rx_byte),
      .nxt     (parse_nxt),
      .evt     (evt)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign take         = req_valid && req_ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value      <= 8'd255;
         cfg_ff.code_only_min   <= 8'd192;
         cfg_ff.byte_param_min  <= 8'd128;
         cfg_ff.word_param_min  <= 8'd64;
         cfg_ff.dword_param_min <= 8'd32;
         cfg_ff.transmit_code   <= 8'd1;
         parse_ff.parse_state     <= ST_SYNC;
         parse_ff.assembly        <= '0;
         parse_ff.checksum        <= CHECKSUM_RESET;
         parse_ff.checksum_done   <= 1'b0;
         parse_ff.command         <= COMMAND_RESET;
         parse_ff.parameter_value <= '0;
         parse_ff.repeat_count    <= '0;
         parse_ff.duty            <= DUTY_RESET;
         parse_ff.period          <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (take) parse_ff <= parse_nxt;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, needs no reset
   always_ff @(posedge clock) begin
      if (take) evt_ff <= evt;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = evt_ff.event_res;
   assign rsp_pulse_width      = evt_ff.pulse_width;
   // latches after the step are exactly the registered parse state
   assign rsp_command_code     = parse_ff.command;
   assign rsp_parameter_value  = parse_ff.parameter_value;
   assign rsp_repeat_count     = parse_ff.repeat_count;
   assign rsp_duty_cycle       = parse_ff.duty;
   assign rsp_carrier_period   = parse_ff.period;
   assign rsp_running_checksum = parse_ff.checksum;
   assign rsp_checksum_closed  = parse_ff.checksum_done;

endmodule

@@ hw/rtl/ircfp_checker.sv @@
// port-level checks of the ir command frame parser and their binding
module ircfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_res,
   input logic [30:0] rsp_pulse_width,
   input logic [6:0]  rsp_duty_cycle,
   input logic [7:0]  rsp_running_checksum,
   input logic        rsp_checksum_closed
);
   import ircfp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_pulse_width) && $stable(rsp_running_checksum))
      else $error("stalled result changed");

   // the parser never stalls unless its result is held
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with free result register");

   // pulse width is only shown with a pulse event
   a_pw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_PULSE |-> rsp_pulse_width == '0)
      else $error("pulse width without pulse event");

   // packet done always comes with a closed checksum
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_DONE |-> rsp_checksum_closed)
      else $error("packet done without closed checksum");

   a_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_cycle <= 7'd100)
      else $error("duty cycle above limit");

endmodule

bind ir_command_frame_parser ircfp_checker u_ircfp_checker (.*);
